// ===== src/pairwise_distance_contact_finder_defines.svh =====
// Assertion macros shared by the contact finder RTL.
// Every macro expects signals named clk and rst in the including module.
`ifndef PAIRWISE_DISTANCE_CONTACT_FINDER_DEFINES_SVH
`define PAIRWISE_DISTANCE_CONTACT_FINDER_DEFINES_SVH

// General property, checked on every rising clock edge outside of reset.
`define PDCF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same-cycle implication from a trigger to a consequence.
`define PDCF_IMPLIES(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cons)) else $error(msg);

// Implication from a trigger to a consequence in the next cycle.
`define PDCF_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) else $error(msg);

`endif

// ===== src/pdcf_pkg.sv =====
// Package for the pairwise distance contact finder: sizes, types and helpers.
// Used by pairwise_distance_contact_finder.sv; depends on nothing else.
package pdcf_pkg;

  // Store capacity and coordinate precision.
  localparam int unsigned MAX_ATOMS  = 64;
  localparam int unsigned COORD_BITS = 20;

  // Derived widths.
  localparam int unsigned ADDR_W  = $clog2(MAX_ATOMS);
  localparam int unsigned CNT_W   = $clog2(MAX_ATOMS + 1);
  localparam int unsigned SQ_W    = 2 * COORD_BITS;
  localparam int unsigned SUM_W   = 2 * COORD_BITS + 2;
  localparam int unsigned CUT_W   = 44;
  localparam int unsigned HIT_W   = 6;
  localparam int unsigned MAX_OUT = 63;

  // Stream packing.
  localparam int unsigned FIELD_W   = 20;
  localparam int unsigned X_LSB     = 0;
  localparam int unsigned Y_LSB     = FIELD_W;
  localparam int unsigned Z_LSB     = 2 * FIELD_W;
  localparam int unsigned S_DATA_W  = 64;
  localparam int unsigned OUT_IDX_W = 6;
  localparam int unsigned M_DATA_W  = 16;
  localparam int unsigned M_PAD_W   = M_DATA_W - 2 * OUT_IDX_W;

  // Default threshold: 3.61 square angstrom in 1/65536 units.
  localparam logic [CUT_W-1:0] CUTOFF_RESET = 44'd236585;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [COORD_BITS-1:0]        mag_t;
  typedef logic [SQ_W-1:0]              sq_t;
  typedef logic [SUM_W-1:0]             sum_t;
  typedef logic [CUT_W-1:0]             cut_t;
  typedef logic [CNT_W-1:0]             count_t;
  typedef logic [ADDR_W-1:0]            addr_t;
  typedef logic [HIT_W-1:0]             hit_t;
  typedef logic [OUT_IDX_W-1:0]         out_idx_t;

  // One stored atom.
  typedef struct packed {
    coord_t z;
    coord_t y;
    coord_t x;
  } atom_t;

  // Magnitude of the difference of two coordinates; always fits COORD_BITS.
  function automatic mag_t abs_diff(coord_t a, coord_t b);
    logic signed [COORD_BITS:0] d;
    d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
    return d[COORD_BITS] ? mag_t'(-d) : mag_t'(d);
  endfunction

endpackage

// ===== src/pairwise_distance_contact_finder.sv =====
// Streaming contact finder: reports every stored atom closer than a cutoff to each new atom.
// Depends on pdcf_pkg and on pairwise_distance_contact_finder_defines.svh for assertions.
//
// Atoms arrive one per transaction; the block compares each new atom against
// all atoms stored since the last start_of_set, reading one stored atom per
// cycle, unless a new contact finds the output register still full, from a
// single-port coordinate memory into a three-stage distance pipeline
// (difference, square, sum) whose output is compared with the cutoff. The input
// is held off while a scan runs, until every stored atom has been read and the
// pipeline has drained, and while a result waits in the output register. An atom
// that becomes index zero or overflows a full store starts no scan. Contacts come out
// in ascending order of the stored index, the last one of the atom marked by
// m_tlast; an atom with no contact gives no transaction. The cutoff register
// may only be written while the block idles.
`include "pairwise_distance_contact_finder_defines.svh"

module pairwise_distance_contact_finder (
  input  logic                             clk,
  input  logic                             rst,
  // Input atoms.
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [pdcf_pkg::S_DATA_W-1:0]    s_tdata,   // x_coord, y_coord, z_coord, zero pad
  input  logic                             s_tuser,   // start_of_set
  // Contact results.
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [pdcf_pkg::M_DATA_W-1:0]    m_tdata,   // earlier_index, new_index, zero pad
  output logic                             m_tuser,   // overflow
  output logic                             m_tlast,   // last_of_run
  // Cutoff register write.
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [pdcf_pkg::CUT_W-1:0]       cfg_data
);

  typedef enum logic {ST_IDLE, ST_SCAN} state_t;

  state_t                  state;
  pdcf_pkg::count_t        atom_count;
  pdcf_pkg::count_t        scan_limit;
  pdcf_pkg::count_t        issue_idx;
  pdcf_pkg::count_t        new_idx;
  pdcf_pkg::cut_t          cutoff;
  pdcf_pkg::hit_t          hit_cnt;
  logic                    pend_valid;
  pdcf_pkg::count_t        pend_idx;
  pdcf_pkg::out_idx_t      earlier_out;
  pdcf_pkg::out_idx_t      new_out;

  // New atom held for the scan.
  pdcf_pkg::atom_t         cur_atom;
  pdcf_pkg::atom_t         in_atom;

  // Coordinate memory.
  pdcf_pkg::atom_t         mem [pdcf_pkg::MAX_ATOMS];
  pdcf_pkg::atom_t         rd_data;

  // Distance pipeline.
  logic                    v1, v2, v3, v4;
  pdcf_pkg::count_t        idx1, idx2, idx3, idx4;
  pdcf_pkg::mag_t          ax, ay, az;
  pdcf_pkg::sq_t           sqx, sqy, sqz;
  pdcf_pkg::sum_t          sum4;

  logic                    in_acc;
  logic                    out_free;
  pdcf_pkg::count_t        eff_count;
  logic                    full;
  logic                    hit_raw;
  logic                    pipe_busy;
  logic                    issue_done;
  logic                    stall;
  logic                    adv;
  logic                    issue;
  logic                    finish;
  logic                    out_load;

  // Handshake and scan control.
  assign cfg_ready  = 1'b1;
  assign out_free   = !m_tvalid || m_tready;
  assign s_tready   = (state == ST_IDLE) && out_free;
  assign in_acc     = s_tvalid && s_tready;
  assign eff_count  = s_tuser ? '0 : atom_count;
  assign full       = eff_count >= pdcf_pkg::count_t'(pdcf_pkg::MAX_ATOMS);
  assign hit_raw    = v4 && (pdcf_pkg::cut_t'(sum4) < cutoff)
                      && (hit_cnt < pdcf_pkg::hit_t'(pdcf_pkg::MAX_OUT));
  assign pipe_busy  = v1 || v2 || v3 || v4;
  assign issue_done = issue_idx == scan_limit;
  assign stall      = hit_raw && pend_valid && !out_free;
  assign adv        = !stall;
  assign issue      = (state == ST_SCAN) && !issue_done && adv;
  assign finish     = (state == ST_SCAN) && issue_done && !pipe_busy
                      && (!pend_valid || out_free);

  // A new result enters the output register on an overflow, on a contact that
  // pushes out the held one, or at the end of a scan with a held contact.
  assign out_load   = ((state == ST_IDLE) && in_acc && full)
                      || ((state == ST_SCAN) && adv && hit_raw && pend_valid)
                      || (finish && pend_valid);

  // Unpack the incoming coordinates, keeping the low COORD_BITS bits of each.
  assign in_atom.x = pdcf_pkg::coord_t'(s_tdata[pdcf_pkg::X_LSB +: pdcf_pkg::COORD_BITS]);
  assign in_atom.y = pdcf_pkg::coord_t'(s_tdata[pdcf_pkg::Y_LSB +: pdcf_pkg::COORD_BITS]);
  assign in_atom.z = pdcf_pkg::coord_t'(s_tdata[pdcf_pkg::Z_LSB +: pdcf_pkg::COORD_BITS]);

  // Output packing.
  assign m_tdata = {{pdcf_pkg::M_PAD_W{1'b0}}, new_out, earlier_out};

  // Coordinate memory: the new atom is written at acceptance, at an index
  // the scan that follows never reads.
  always_ff @(posedge clk) begin
    if (in_acc && !full) begin
      mem[eff_count[pdcf_pkg::ADDR_W-1:0]] <= in_atom;
    end
    if (issue) begin
      rd_data <= mem[issue_idx[pdcf_pkg::ADDR_W-1:0]];
    end
  end

  // Distance datapath: difference, square, sum.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cur_atom <= in_atom;
    end
    if (adv) begin
      idx1 <= issue_idx;
      idx2 <= idx1;
      ax   <= pdcf_pkg::abs_diff(cur_atom.x, rd_data.x);
      ay   <= pdcf_pkg::abs_diff(cur_atom.y, rd_data.y);
      az   <= pdcf_pkg::abs_diff(cur_atom.z, rd_data.z);
      idx3 <= idx2;
      sqx  <= pdcf_pkg::sq_t'(ax) * pdcf_pkg::sq_t'(ax);
      sqy  <= pdcf_pkg::sq_t'(ay) * pdcf_pkg::sq_t'(ay);
      sqz  <= pdcf_pkg::sq_t'(az) * pdcf_pkg::sq_t'(az);
      idx4 <= idx3;
      sum4 <= pdcf_pkg::sum_t'(sqx) + pdcf_pkg::sum_t'(sqy) + pdcf_pkg::sum_t'(sqz);
    end
  end

  // State machine, counters and registered outputs. A found contact is held
  // back one step so the final one of the scan can carry the last flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      atom_count  <= '0;
      scan_limit  <= '0;
      issue_idx   <= '0;
      new_idx     <= '0;
      cutoff      <= pdcf_pkg::CUTOFF_RESET;
      hit_cnt     <= '0;
      pend_valid  <= 1'b0;
      pend_idx    <= '0;
      v1          <= 1'b0;
      v2          <= 1'b0;
      v3          <= 1'b0;
      v4          <= 1'b0;
      m_tvalid    <= 1'b0;
      m_tuser     <= 1'b0;
      m_tlast     <= 1'b0;
      earlier_out <= '0;
      new_out     <= '0;
    end else begin
      if (cfg_valid) begin
        cutoff <= cfg_data;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            if (full) begin
              m_tuser     <= 1'b1;
              m_tlast     <= 1'b1;
              earlier_out <= '0;
              new_out     <= '0;
              atom_count  <= eff_count;
            end else begin
              atom_count <= pdcf_pkg::count_t'(eff_count + 1'b1);
              new_idx    <= eff_count;
              scan_limit <= eff_count;
              issue_idx  <= '0;
              hit_cnt    <= '0;
              pend_valid <= 1'b0;
              if (eff_count != '0) begin
                state <= ST_SCAN;
              end
            end
          end
        end
        ST_SCAN: begin
          if (adv) begin
            v1 <= issue;
            v2 <= v1;
            v3 <= v2;
            v4 <= v3;
            if (issue) begin
              issue_idx <= pdcf_pkg::count_t'(issue_idx + 1'b1);
            end
            if (hit_raw) begin
              hit_cnt    <= pdcf_pkg::hit_t'(hit_cnt + 1'b1);
              pend_idx   <= idx4;
              pend_valid <= 1'b1;
              if (pend_valid) begin
                m_tuser     <= 1'b0;
                m_tlast     <= 1'b0;
                earlier_out <= pdcf_pkg::out_idx_t'(pend_idx);
                new_out     <= pdcf_pkg::out_idx_t'(new_idx);
              end
            end
          end
          if (finish) begin
            state      <= ST_IDLE;
            pend_valid <= 1'b0;
            if (pend_valid) begin
              m_tuser     <= 1'b0;
              m_tlast     <= 1'b1;
              earlier_out <= pdcf_pkg::out_idx_t'(pend_idx);
              new_out     <= pdcf_pkg::out_idx_t'(new_idx);
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Distance samples only exist while a scan runs.
  `PDCF_IMPLIES(a_pipe_in_scan, v4 || pend_valid, state == ST_SCAN, "busy outside scan")
  // The read pointer never passes the number of atoms stored before this one.
  `PDCF_ASSERT(a_issue_bound, issue_idx <= scan_limit, "read index ran past the stored set")
  // A start flag leaves exactly the new atom in the store.
  `PDCF_NEXT(a_start_count, in_acc && s_tuser, atom_count == pdcf_pkg::count_t'(1), "no restart")
  // The held-back contact of a finished scan goes out marked as the last.
  `PDCF_NEXT(a_finish_last, finish && pend_valid, m_tvalid && m_tlast, "last flag missing")

endmodule

// ===== sim/pairwise_distance_contact_finder_tb.sv =====
`timescale 1ns / 1ps
// Testbench for pairwise_distance_contact_finder: streams sets of atoms, predicts every
// contact pair in a scoreboard and checks the result stream field by field.
// Depends on pdcf_pkg and the pairwise_distance_contact_finder RTL.

// One result transaction, first field in the most significant bits.
typedef struct packed {
  pdcf_pkg::out_idx_t earlier_index;
  pdcf_pkg::out_idx_t new_index;
  logic               overflow;
  logic               last_of_run;
} contact_t;

// Keeps its own copy of the atom store and the cutoff, and queues the
// contacts that each accepted atom must produce.
class contact_scoreboard;
  pdcf_pkg::atom_t stored[pdcf_pkg::MAX_ATOMS];
  int unsigned     stored_count;
  pdcf_pkg::cut_t  cutoff;
  contact_t        expected[$];
  int unsigned     mismatches;
  int unsigned     atoms_seen;
  int unsigned     contacts_seen;
  int unsigned     overflows_seen;

  function new();
    stored_count   = 0;
    cutoff         = pdcf_pkg::CUTOFF_RESET;
    mismatches     = 0;
    atoms_seen     = 0;
    contacts_seen  = 0;
    overflows_seen = 0;
  endfunction

  function void set_cutoff(pdcf_pkg::cut_t value);
    cutoff = value;
  endfunction

  // Exact squared distance in 1/65536 square angstrom units.
  function longint squared_distance(pdcf_pkg::atom_t a, pdcf_pkg::atom_t b);
    pdcf_pkg::coord_t ax, ay, az, bx, by, bz;
    longint dx, dy, dz;
    ax = a.x;
    ay = a.y;
    az = a.z;
    bx = b.x;
    by = b.y;
    bz = b.z;
    dx = longint'(ax) - longint'(bx);
    dy = longint'(ay) - longint'(by);
    dz = longint'(az) - longint'(bz);
    return dx * dx + dy * dy + dz * dz;
  endfunction

  // Predicts the contacts of one accepted atom and stores it.
  function void note_atom(logic start_of_set, pdcf_pkg::atom_t atom);
    int unsigned hits[$];
    int unsigned i;
    contact_t    c;
    atoms_seen++;
    if (start_of_set) begin
      stored_count = 0;
    end
    // A full store drops the atom and flags it once.
    if (stored_count >= pdcf_pkg::MAX_ATOMS) begin
      c.earlier_index = '0;
      c.new_index     = '0;
      c.overflow      = 1'b1;
      c.last_of_run   = 1'b1;
      expected = {expected, c};
      return;
    end
    // Scan stored atoms in index order; the run is capped at MAX_OUT contacts.
    for (i = 0; i < stored_count && hits.size() < pdcf_pkg::MAX_OUT; i++) begin
      if (squared_distance(atom, stored[i]) < longint'(cutoff)) begin
        hits = {hits, i};
      end
    end
    for (i = 0; i < hits.size(); i++) begin
      c.earlier_index = pdcf_pkg::out_idx_t'(hits[i]);
      c.new_index     = pdcf_pkg::out_idx_t'(stored_count);
      c.overflow      = 1'b0;
      c.last_of_run   = (i == hits.size() - 1);
      expected = {expected, c};
    end
    stored[stored_count] = atom;
    stored_count++;
  endfunction

  task report_mismatch(string what);
    mismatches++;
    $display("MISMATCH at %0t ns: %s", $time, what);
  endtask

  // Compares one result transaction with the oldest expected contact.
  task check_contact(contact_t got);
    contact_t want;
    if (expected.size() == 0) begin
      report_mismatch($sformatf("unexpected result %0d-%0d ovf=%0b last=%0b",
                                got.earlier_index, got.new_index, got.overflow,
                                got.last_of_run));
      return;
    end
    want = expected.pop_front();
    contacts_seen++;
    if (want.overflow) begin
      overflows_seen++;
    end
    if (got.earlier_index !== want.earlier_index) begin
      report_mismatch($sformatf("earlier_index %0d, expected %0d",
                                got.earlier_index, want.earlier_index));
    end
    if (got.new_index !== want.new_index) begin
      report_mismatch($sformatf("new_index %0d, expected %0d",
                                got.new_index, want.new_index));
    end
    if (got.overflow !== want.overflow) begin
      report_mismatch($sformatf("overflow %0b, expected %0b", got.overflow, want.overflow));
    end
    if (got.last_of_run !== want.last_of_run) begin
      report_mismatch($sformatf("last_of_run %0b, expected %0b",
                                got.last_of_run, want.last_of_run));
    end
  endtask
endclass

module pairwise_distance_contact_finder_tb;

  // Wait to let an atom without contacts finish its scan of up to 63 stored atoms and drain the pipeline.
  localparam int unsigned    SETTLE_CYCLES  = 80;
  localparam int unsigned    QUIET_LIMIT    = 3000;
  localparam int unsigned    SQUEEZE_CYCLES = 300;
  localparam pdcf_pkg::cut_t CUTOFF_MAX     = '1;

  logic                          clk       = 1'b0;
  logic                          rst       = 1'b1;
  logic                          s_tvalid  = 1'b0;
  logic                          s_tready;
  logic [pdcf_pkg::S_DATA_W-1:0] s_tdata   = '0;   // x_coord, y_coord, z_coord, zero pad
  logic                          s_tuser   = 1'b0; // start_of_set
  logic                          m_tvalid;
  logic                          m_tready  = 1'b0;
  logic [pdcf_pkg::M_DATA_W-1:0] m_tdata;          // earlier_index, new_index, zero pad
  logic                          m_tuser;          // overflow
  logic                          m_tlast;          // last_of_run
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  pdcf_pkg::cut_t                cfg_data  = '0;

  int unsigned       src_idle_pct    = 0;
  int unsigned       sink_stall_pct  = 0;
  bit                squeeze_request = 1'b0;
  int unsigned       squeeze_left    = 0;
  int unsigned       cutoff_writes   = 0;
  contact_scoreboard sb              = new();

  pairwise_distance_contact_finder u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Result receiver: random stalls, or a long hold-off when one is requested.
  always @(posedge clk) begin
    if (squeeze_request) begin
      squeeze_request = 1'b0;
      squeeze_left    = SQUEEZE_CYCLES;
    end
    if (squeeze_left != 0) begin
      squeeze_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Transaction monitor for all three channels.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        sb.set_cutoff(cfg_data);
        cutoff_writes++;
      end
      if (s_tvalid && s_tready) begin
        sb.note_atom(s_tuser, pdcf_pkg::atom_t'(s_tdata[3*pdcf_pkg::COORD_BITS-1:0]));
      end
      if (m_tvalid && m_tready) begin
        sb.check_contact({m_tdata[pdcf_pkg::OUT_IDX_W-1:0],
                          m_tdata[2*pdcf_pkg::OUT_IDX_W-1:pdcf_pkg::OUT_IDX_W],
                          m_tuser, m_tlast});
      end
    end
  end

  // Watchdog: ends the run when no transaction happens for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Timeout: no transaction for %0d cycles.", QUIET_LIMIT);
    $display("pairwise_distance_contact_finder_tb NOT OK");
    $finish;
  end

  // Offers one atom, idling at random first, and returns once it is accepted.
  task automatic send_atom(input logic start, input pdcf_pkg::atom_t atom);
    bit lowered;
    lowered = 1'b0;
    while ($urandom_range(99) < src_idle_pct) begin
      if (!lowered) begin
        s_tvalid <= 1'b0;
      end
      lowered = 1'b1;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= start;
    s_tdata  <= {{(pdcf_pkg::S_DATA_W - 3 * pdcf_pkg::COORD_BITS){1'b0}}, atom};
    @(posedge clk);
    while (!s_tready) begin
      @(posedge clk);
    end
  endtask

  task automatic send_xyz(input logic start, input int x, input int y, input int z);
    pdcf_pkg::atom_t a;
    a.x = pdcf_pkg::coord_t'(x);
    a.y = pdcf_pkg::coord_t'(y);
    a.z = pdcf_pkg::coord_t'(z);
    send_atom(start, a);
  endtask

  // Stops the input and waits until every expected contact has come and the scan is over.
  task automatic quiesce();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.expected.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cutoff(input pdcf_pkg::cut_t value);
    quiesce();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic pdcf_pkg::coord_t jitter(pdcf_pkg::coord_t c, int unsigned span);
    return pdcf_pkg::coord_t'(int'(c) + int'($urandom_range(2 * span)) - int'(span));
  endfunction

  function automatic pdcf_pkg::atom_t random_atom();
    pdcf_pkg::atom_t a;
    a.x = pdcf_pkg::coord_t'($urandom);
    a.y = pdcf_pkg::coord_t'($urandom);
    a.z = pdcf_pkg::coord_t'($urandom);
    return a;
  endfunction

  // Random molecules: clusters around a random center with some scattered atoms.
  // A forced first set is long enough to fill the store and overflow it twice.
  task automatic run_phase(input int unsigned src_pct, input int unsigned sink_pct,
                           input pdcf_pkg::cut_t cutoff, input int unsigned span,
                           input int unsigned n_items, input bit fill_first,
                           input bit squeeze);
    int unsigned     sent;
    int unsigned     len;
    int unsigned     k;
    bit              first;
    bit              sos;
    pdcf_pkg::atom_t center;
    pdcf_pkg::atom_t a;
    write_cutoff(cutoff);
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    sent  = 0;
    first = 1'b1;
    while (sent < n_items) begin
      if (first && fill_first) begin
        len = pdcf_pkg::MAX_ATOMS + 2;
      end else if ($urandom_range(3) == 0) begin
        len = $urandom_range(68, 50);
      end else begin
        len = $urandom_range(16, 1);
      end
      if (first && squeeze) begin
        squeeze_request = 1'b1;
      end
      center = random_atom();
      for (k = 0; k < len; k++) begin
        if ($urandom_range(4) == 0) begin
          a = random_atom();
        end else begin
          a.x = jitter(center.x, span);
          a.y = jitter(center.y, span);
          a.z = jitter(center.z, span);
        end
        // Now and then a set restarts in the middle.
        sos = (k == 0) || (!(first && fill_first) && $urandom_range(29) == 0);
        send_atom(sos, a);
        sent++;
      end
      first = 1'b0;
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    src_idle_pct   = 34;
    sink_stall_pct = 58;

    // Default cutoff: near contacts, the exact-threshold boundary and the coordinate extremes.
    send_xyz(1'b1, 0, 0, 0);
    send_xyz(1'b0, 100, 0, 0);
    send_xyz(1'b0, 486, 10, 17);    // squared distance to atom 0 equals the cutoff
    send_xyz(1'b0, 486, 10, 16);    // squared distance to atom 0 is 33 below the cutoff
    send_xyz(1'b0, -524288, -524288, -524288);
    send_xyz(1'b0, 524287, 524287, 524287);
    send_xyz(1'b0, -524288, -524288, -524287);
    send_xyz(1'b1, 524287, -524288, 0);
    send_xyz(1'b0, 524287, -524288, 5);

    // Zero cutoff: even identical atoms are not in contact.
    write_cutoff('0);
    send_xyz(1'b1, 1234, -5678, 42);
    send_xyz(1'b0, 1234, -5678, 42);

    // Largest cutoff: every pair is in contact, even opposite corners.
    write_cutoff(CUTOFF_MAX);
    send_xyz(1'b1, -524288, 524287, -524288);
    send_xyz(1'b0, 524287, -524288, 524287);
    send_xyz(1'b0, 0, 0, 0);

    run_phase(34, 58, pdcf_pkg::CUTOFF_RESET, 400, 122, 1'b1, 1'b0);
    run_phase(58, 34, pdcf_pkg::cut_t'($urandom_range(5000000, 1000000)), 2000, 122,
              1'b0, 1'b0);
    run_phase(0, 0, pdcf_pkg::cut_t'({8'($urandom_range(255, 64)), $urandom}), 300000, 122,
              1'b1, 1'b1);
    quiesce();

    $display("Run covered %0d atoms and %0d result transactions (%0d overflow) over %0d",
             sb.atoms_seen, sb.contacts_seen, sb.overflows_seen, cutoff_writes + 1);
    $display("cutoff settings, with idle sweeps on both sides and a long result hold-off.");
    if (sb.mismatches == 0) begin
      $display("pairwise_distance_contact_finder_tb OK");
    end else begin
      $display("pairwise_distance_contact_finder_tb NOT OK");
    end
    $finish;
  end

endmodule
